FILE: src/pee_pkg.sv
// shared types and constants for the postfix expression evaluator
// character codes, status codes and the arithmetic unit request/response
// depends on nothing; used by every other file of the block but pee_ram
package pee_pkg;

    localparam int DATA_W = 32;
    localparam int CHAR_W = 8;
    localparam int STAT_W = 3;

    localparam logic [CHAR_W-1:0] CH_NUL   = 8'h00;
    localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
    localparam logic [CHAR_W-1:0] CH_CR    = 8'h0D;
    localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
    localparam logic [CHAR_W-1:0] CH_COMMA = 8'h2C;
    localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2B;
    localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
    localparam logic [CHAR_W-1:0] CH_STAR  = 8'h2A;
    localparam logic [CHAR_W-1:0] CH_SLASH = 8'h2F;
    localparam logic [CHAR_W-1:0] CH_CARET = 8'h5E;
    localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0] CH_NINE  = 8'h39;
    localparam logic [CHAR_W-1:0] CH_UP_A  = 8'h41;
    localparam logic [CHAR_W-1:0] CH_UP_Z  = 8'h5A;
    localparam logic [CHAR_W-1:0] CH_LO_A  = 8'h61;
    localparam logic [CHAR_W-1:0] CH_LO_Z  = 8'h7A;
    localparam logic [CHAR_W-1:0] CASE_BIT = 8'h20;

    localparam logic [STAT_W-1:0] ST_OK      = 3'd0;
    localparam logic [STAT_W-1:0] ST_BADOP   = 3'd1;
    localparam logic [STAT_W-1:0] ST_UNDER   = 3'd2;
    localparam logic [STAT_W-1:0] ST_OVER    = 3'd3;
    localparam logic [STAT_W-1:0] ST_DIVZERO = 3'd4;

    localparam logic [DATA_W-1:0] ALL_ONES = '1;

    typedef enum logic [2:0] {
        OP_ADD = 3'd0,
        OP_SUB = 3'd1,
        OP_MUL = 3'd2,
        OP_DIV = 3'd3,
        OP_POW = 3'd4
    } alu_op_t;

    typedef struct packed {
        logic    start;
        alu_op_t op;
    } alu_req_t;

    typedef struct packed {
        logic              done;
        logic              div_zero;
        logic [DATA_W-1:0] result;
    } alu_rsp_t;

endpackage

FILE: src/pee_in_if.sv
// input channel: one expression character and its variable value per beat
// depends on pee_pkg
interface pee_in_if;
    logic                                   valid;
    logic                                   ready;
    logic        [pee_pkg::CHAR_W-1:0]      char_code;
    logic signed [pee_pkg::DATA_W-1:0]      var_value;

    modport source (output valid, output char_code, output var_value, input ready);
    modport sink   (input valid, input char_code, input var_value, output ready);
endinterface

FILE: src/pee_out_if.sv
// output channel: final value and status, one beat per expression
// depends on pee_pkg
interface pee_out_if;
    logic                                   valid;
    logic                                   ready;
    logic signed [pee_pkg::DATA_W-1:0]      result_value;
    logic        [pee_pkg::STAT_W-1:0]      status_code;

    modport source (output valid, output result_value, output status_code, input ready);
    modport sink   (input valid, input result_value, input status_code, output ready);
endinterface

FILE: src/pee_ram.sv
// generic single write port, single read port ram with registered read data
// depends on nothing
module pee_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 128
) (
    input  logic                                     clk,
    input  logic                                     we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                         wdata,
    input  logic                                     re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: src/pee_alu.sv
// shared arithmetic unit: add, subtract, multiply in one pass,
// restoring divide one bit per cycle, square-and-multiply power on one multiplier
// depends on pee_pkg
module pee_alu (
    input  logic                      clk,
    input  logic                      rst_n,
    input  pee_pkg::alu_req_t         req,
    input  logic [pee_pkg::DATA_W-1:0] opa,
    input  logic [pee_pkg::DATA_W-1:0] opb,
    output pee_pkg::alu_rsp_t         rsp
);
    import pee_pkg::*;

    localparam int CNT_W = $clog2(DATA_W);

    typedef enum logic [4:0] {
        A_IDLE = 5'b00001,
        A_DIV  = 5'b00010,
        A_SIGN = 5'b00100,
        A_POW  = 5'b01000,
        A_DONE = 5'b10000
    } alu_state_t;

    alu_state_t        state_reg, state_next;
    logic [DATA_W-1:0] res_reg, res_next;
    logic              dz_reg, dz_next;
    logic [DATA_W-1:0] acc_reg, acc_next;
    logic [DATA_W-1:0] sq_reg, sq_next;
    logic [DATA_W-1:0] exp_reg, exp_next;
    logic              phase_reg, phase_next;
    logic [DATA_W-1:0] rem_reg, rem_next;
    logic [DATA_W-1:0] quo_reg, quo_next;
    logic [DATA_W-1:0] dvs_reg, dvs_next;
    logic              neg_reg, neg_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;

    logic [DATA_W-1:0] mul_x, mul_y, prod;
    logic [DATA_W:0]   trial;
    logic              fits;
    logic [DATA_W-1:0] mag_a, mag_b;

    assign prod  = mul_x * mul_y;
    assign trial = {rem_reg, quo_reg[DATA_W-1]};
    assign fits  = trial >= {1'b0, dvs_reg};
    assign mag_a = opa[DATA_W-1] ? (DATA_W'(0) - opa) : opa;
    assign mag_b = opb[DATA_W-1] ? (DATA_W'(0) - opb) : opb;

    always_comb
    begin
        state_next = state_reg;
        res_next   = res_reg;
        dz_next    = dz_reg;
        acc_next   = acc_reg;
        sq_next    = sq_reg;
        exp_next   = exp_reg;
        phase_next = phase_reg;
        rem_next   = rem_reg;
        quo_next   = quo_reg;
        dvs_next   = dvs_reg;
        neg_next   = neg_reg;
        cnt_next   = cnt_reg;
        mul_x      = opa;
        mul_y      = opb;
        case (state_reg)
            A_IDLE:
            begin
                if (req.start)
                begin
                    dz_next    = 1'b0;
                    state_next = A_DONE;
                    case (req.op)
                        OP_ADD: res_next = opa + opb;
                        OP_SUB: res_next = opa - opb;
                        OP_MUL: res_next = prod;
                        OP_DIV:
                        begin
                            if (opb == '0)
                            begin
                                res_next = '0;
                                dz_next  = 1'b1;
                            end
                            else
                            begin
                                quo_next   = mag_a;
                                dvs_next   = mag_b;
                                rem_next   = '0;
                                neg_next   = opa[DATA_W-1] ^ opb[DATA_W-1];
                                cnt_next   = '0;
                                state_next = A_DIV;
                            end
                        end
                        OP_POW:
                        begin
                            if (opb[DATA_W-1])
                            begin
                                if (opa == DATA_W'(1))
                                begin
                                    res_next = DATA_W'(1);
                                end
                                else if (opa == ALL_ONES)
                                begin
                                    res_next = opb[0] ? ALL_ONES : DATA_W'(1);
                                end
                                else
                                begin
                                    res_next = '0;
                                end
                            end
                            else
                            begin
                                acc_next   = DATA_W'(1);
                                sq_next    = opa;
                                exp_next   = opb;
                                phase_next = 1'b0;
                                state_next = A_POW;
                            end
                        end
                        default: res_next = '0;
                    endcase
                end
            end
            A_DIV:
            begin
                if (fits)
                begin
                    rem_next = DATA_W'(trial - {1'b0, dvs_reg});
                end
                else
                begin
                    rem_next = trial[DATA_W-1:0];
                end
                quo_next = {quo_reg[DATA_W-2:0], fits};
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(DATA_W - 1))
                begin
                    state_next = A_SIGN;
                end
            end
            A_SIGN:
            begin
                res_next   = neg_reg ? (DATA_W'(0) - quo_reg) : quo_reg;
                state_next = A_DONE;
            end
            A_POW:
            begin
                if (exp_reg == '0)
                begin
                    res_next   = acc_reg;
                    state_next = A_DONE;
                end
                else if (exp_reg[0] && !phase_reg)
                begin
                    mul_x      = acc_reg;
                    mul_y      = sq_reg;
                    acc_next   = prod;
                    phase_next = 1'b1;
                end
                else
                begin
                    mul_x      = sq_reg;
                    mul_y      = sq_reg;
                    sq_next    = prod;
                    exp_next   = exp_reg >> 1;
                    phase_next = 1'b0;
                end
            end
            A_DONE:
            begin
                state_next = A_IDLE;
            end
            default:
            begin
                state_next = A_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= A_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        res_reg   <= res_next;
        dz_reg    <= dz_next;
        acc_reg   <= acc_next;
        sq_reg    <= sq_next;
        exp_reg   <= exp_next;
        phase_reg <= phase_next;
        rem_reg   <= rem_next;
        quo_reg   <= quo_next;
        dvs_reg   <= dvs_next;
        neg_reg   <= neg_next;
        cnt_reg   <= cnt_next;
    end

    assign rsp.done     = (state_reg == A_DONE);
    assign rsp.div_zero = dz_reg;
    assign rsp.result   = res_reg;

endmodule

FILE: src/postfix_expression_evaluator_top.sv
// Postfix expression evaluator, one character per beat on expr, one result beat on
// result for each end-of-expression character. Items are taken one at a time, the
// next only when the last is done. Divide runs one quotient bit per cycle in the
// shared unit; power uses one multiplier shared by squaring and accumulating, so
// squaring and the multiply for each set exponent bit take turns. End of expression
// also waits for a stalled result beat to be taken. No clearing pass after reset.
// The operand stack is a ram read one entry per cycle, so a binary operator pops both
// operands, in S_DECODE and S_POP_A, before the shared unit starts.
// depends on pee_pkg, pee_in_if, pee_out_if, pee_ram, pee_alu
module postfix_expression_evaluator_top #(
    parameter int STACK_DEPTH = 128,
    parameter int VAR_COUNT   = 26
) (
    input  logic      clk,
    input  logic      rst_n,
    pee_in_if.sink    expr,
    pee_out_if.source result
);
    import pee_pkg::*;

    localparam int CNT_W  = $clog2(STACK_DEPTH + 1);
    localparam int ADDR_W = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int VIDX_W = (VAR_COUNT > 1) ? $clog2(VAR_COUNT) : 1;

    typedef enum logic [6:0] {
        S_IDLE   = 7'b0000001,
        S_DECODE = 7'b0000010,
        S_POP_A  = 7'b0000100,
        S_EXEC   = 7'b0001000,
        S_WAIT   = 7'b0010000,
        S_FIN_RD = 7'b0100000,
        S_FINISH = 7'b1000000
    } state_t;

    state_t              state_reg, state_next;
    logic [CHAR_W-1:0]   char_reg, char_next;
    logic [DATA_W-1:0]   val_reg, val_next;
    logic [CNT_W-1:0]    count_reg, count_next;
    logic [STAT_W-1:0]   err_reg, err_next;
    logic [VAR_COUNT-1:0] known_reg, known_next;
    logic [DATA_W-1:0]   var_reg [VAR_COUNT];
    logic                hit_reg, hit_next;
    logic [DATA_W-1:0]   b_reg, b_next;
    logic [DATA_W-1:0]   top_reg, top_next;
    logic                out_valid_reg, out_valid_next;
    logic [DATA_W-1:0]   out_value_reg, out_value_next;
    logic [STAT_W-1:0]   out_status_reg, out_status_next;

    logic [CHAR_W-1:0]   ch_fold;
    logic [CHAR_W-1:0]   letter_ofs;
    logic                is_skip, is_digit, is_letter;
    logic [VIDX_W-1:0]   var_idx;
    logic                var_we;
    logic                push_en, pop_en, set_badop, clear_all;
    logic [DATA_W-1:0]   push_data, pop_data;
    logic [STAT_W-1:0]   err_note;
    logic                ram_we, ram_re;
    logic [ADDR_W-1:0]   ram_waddr, ram_raddr;
    logic [DATA_W-1:0]   ram_rdata;
    alu_req_t            alu_req;
    alu_rsp_t            alu_rsp;

    assign ch_fold = (char_reg >= CH_UP_A && char_reg <= CH_UP_Z) ?
                     (char_reg | CASE_BIT) : char_reg;
    assign is_skip = (char_reg == CH_SPACE) || (char_reg == CH_COMMA) ||
                     (char_reg >= CH_TAB && char_reg <= CH_CR);
    assign is_digit   = (char_reg >= CH_ZERO) && (char_reg <= CH_NINE);
    assign letter_ofs = ch_fold - CH_LO_A;
    assign is_letter  = (ch_fold >= CH_LO_A) && (ch_fold <= CH_LO_Z) &&
                        (letter_ofs < CHAR_W'(VAR_COUNT));
    assign var_idx    = letter_ofs[VIDX_W-1:0];
    assign pop_data   = hit_reg ? ram_rdata : ALL_ONES;

    assign expr.ready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next      = state_reg;
        char_next       = char_reg;
        val_next        = val_reg;
        count_next      = count_reg;
        err_next        = err_reg;
        known_next      = known_reg;
        hit_next        = hit_reg;
        b_next          = b_reg;
        top_next        = top_reg;
        out_valid_next  = out_valid_reg && !result.ready;
        out_value_next  = out_value_reg;
        out_status_next = out_status_reg;
        var_we          = 1'b0;
        push_en         = 1'b0;
        push_data       = '0;
        pop_en          = 1'b0;
        set_badop       = 1'b0;
        clear_all       = 1'b0;
        err_note        = ST_OK;
        ram_we          = 1'b0;
        ram_waddr       = '0;
        ram_re          = 1'b0;
        ram_raddr       = '0;
        alu_req.start   = 1'b0;
        alu_req.op      = OP_ADD;
        case (state_reg)
            S_IDLE:
            begin
                if (expr.valid)
                begin
                    char_next  = expr.char_code;
                    val_next   = expr.var_value;
                    state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                state_next = S_IDLE;
                if (char_reg == CH_NUL)
                begin
                    if (count_reg != '0)
                    begin
                        ram_re     = 1'b1;
                        ram_raddr  = ADDR_W'(count_reg - 1'b1);
                        state_next = S_FIN_RD;
                    end
                    else
                    begin
                        top_next   = ALL_ONES;
                        err_note   = ST_UNDER;
                        state_next = S_FINISH;
                    end
                end
                else if (err_reg == ST_BADOP || is_skip)
                begin
                    state_next = S_IDLE;
                end
                else if (is_digit)
                begin
                    push_en   = 1'b1;
                    push_data = DATA_W'(char_reg - CH_ZERO);
                end
                else if (is_letter)
                begin
                    push_en = 1'b1;
                    if (known_reg[var_idx])
                    begin
                        push_data = var_reg[var_idx];
                    end
                    else
                    begin
                        push_data           = val_reg;
                        var_we              = 1'b1;
                        known_next[var_idx] = 1'b1;
                    end
                end
                else
                begin
                    pop_en     = 1'b1;
                    state_next = S_POP_A;
                end
            end
            S_POP_A:
            begin
                b_next     = pop_data;
                pop_en     = 1'b1;
                state_next = S_EXEC;
            end
            S_EXEC:
            begin
                state_next = S_WAIT;
                case (char_reg)
                    CH_PLUS:  alu_req.op = OP_ADD;
                    CH_MINUS: alu_req.op = OP_SUB;
                    CH_STAR:  alu_req.op = OP_MUL;
                    CH_SLASH: alu_req.op = OP_DIV;
                    CH_CARET: alu_req.op = OP_POW;
                    default:
                    begin
                        set_badop  = 1'b1;
                        state_next = S_IDLE;
                    end
                endcase
                alu_req.start = !set_badop;
            end
            S_WAIT:
            begin
                if (alu_rsp.done)
                begin
                    push_en    = 1'b1;
                    push_data  = alu_rsp.result;
                    state_next = S_IDLE;
                    if (alu_rsp.div_zero)
                    begin
                        err_note = ST_DIVZERO;
                    end
                end
            end
            S_FIN_RD:
            begin
                top_next   = ram_rdata;
                state_next = S_FINISH;
            end
            S_FINISH:
            begin
                if (!out_valid_reg || result.ready)
                begin
                    out_valid_next  = 1'b1;
                    out_value_next  = (err_reg == ST_BADOP) ? ALL_ONES : top_reg;
                    out_status_next = err_reg;
                    clear_all       = 1'b1;
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // stack pointer and ram port
        if (push_en)
        begin
            if (count_reg == CNT_W'(STACK_DEPTH))
            begin
                if (err_note == ST_OK)
                begin
                    err_note = ST_OVER;
                end
            end
            else
            begin
                ram_we     = 1'b1;
                ram_waddr  = ADDR_W'(count_reg);
                count_next = count_reg + 1'b1;
            end
        end
        if (pop_en)
        begin
            if (count_reg == '0)
            begin
                hit_next = 1'b0;
                err_note = ST_UNDER;
            end
            else
            begin
                hit_next   = 1'b1;
                ram_re     = 1'b1;
                ram_raddr  = ADDR_W'(count_reg - 1'b1);
                count_next = count_reg - 1'b1;
            end
        end

        // first error wins, bad operator overrides
        if (err_reg == ST_OK && err_note != ST_OK)
        begin
            err_next = err_note;
        end
        if (set_badop)
        begin
            err_next = ST_BADOP;
        end
        if (clear_all)
        begin
            err_next   = ST_OK;
            count_next = '0;
            known_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            err_reg       <= ST_OK;
            known_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            err_reg       <= err_next;
            known_reg     <= known_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        char_reg       <= char_next;
        val_reg        <= val_next;
        hit_reg        <= hit_next;
        b_reg          <= b_next;
        top_reg        <= top_next;
        out_value_reg  <= out_value_next;
        out_status_reg <= out_status_next;
        if (var_we)
        begin
            var_reg[var_idx] <= val_reg;
        end
    end

    pee_ram #(
        .WIDTH (DATA_W),
        .DEPTH (STACK_DEPTH)
    ) u_stack_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (push_data),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    pee_alu u_alu (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (alu_req),
        .opa   (pop_data),
        .opb   (b_reg),
        .rsp   (alu_rsp)
    );

    assign result.valid        = out_valid_reg;
    assign result.result_value = out_value_reg;
    assign result.status_code  = out_status_reg;

endmodule

FILE: src/pee_checker.sv
// port-level checks for the postfix evaluator top level, attached by bind
// depends on pee_pkg and postfix_expression_evaluator_top
module pee_checker (
    input logic                         clk,
    input logic                         rst_n,
    input logic                         expr_valid,
    input logic                         expr_ready,
    input logic                         result_valid,
    input logic                         result_ready,
    input logic [pee_pkg::DATA_W-1:0]   result_value,
    input logic [pee_pkg::STAT_W-1:0]   status_code
);
    import pee_pkg::*;

    // a stalled result beat holds
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> result_valid && $stable(result_value)
                                          && $stable(status_code))
        else $error("result beat changed while stalled");

    // each accepted character is worked on before the next one is taken
    assert property (@(posedge clk) disable iff (!rst_n)
        expr_valid && expr_ready |=> !expr_ready)
        else $error("input taken on consecutive cycles");

    // a new result beat only comes out of the busy sequencer
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result_valid) |-> $past(!expr_ready))
        else $error("result appeared while idle");

    // bad operator forces the all-ones value, and status stays in range
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (status_code <= ST_DIVZERO) &&
                         (status_code != ST_BADOP || result_value == ALL_ONES))
        else $error("result status inconsistent");

endmodule

bind postfix_expression_evaluator_top pee_checker u_pee_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .expr_valid   (expr.valid),
    .expr_ready   (expr.ready),
    .result_valid (result.valid),
    .result_ready (result.ready),
    .result_value (result.result_value),
    .status_code  (result.status_code)
);
